// ===== hdl/upd_pkg.sv =====
// shared types, character constants and hex helpers for the url percent decoder
package upd_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      PEND_NONE    = 2'd0,
      PEND_PERCENT = 2'd1,
      PEND_DIGIT   = 2'd2,
      PEND_UNUSED  = 2'd3
   } pend_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } result_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         v = c - CH_LOWER_A + 8'd10;
      end else begin
         v = c - CH_UPPER_A + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

// ===== hdl/url_percent_decoder.sv =====
// url percent decoder: decodes '+' and %xx escapes into a byte stream
// decoded bytes enter a registered result queue and leave on rsp in order
// throughput: one request per cycle while req_stall is low; decode logic sits
// between the request port and the four-entry queue, which drains one byte per
// cycle while rsp_stall is low; requests stall while two or more are queued
// reset (synchronous, active high) empties the queue and drops any held escape
module url_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   upd_pkg::pend_type   pend_ff, pend_in;
   logic [7:0]          digit_ff, digit_in;
   upd_pkg::result_type queue_ff [upd_pkg::QUEUE_DEPTH];
   logic [1:0]          head_ff, head_in;
   logic [2:0]          count_ff, count_in;

   upd_pkg::result_type emit_val [upd_pkg::MAX_RESULTS];
   logic [1:0]          emit_n;
   logic                req_accept;
   logic                rsp_accept;
   logic                plain_hold;
   logic [7:0]          plain_byte;
   logic                c_hex;
   logic [7:0]          decoded;

   // room for three more while at most one entry is queued
   assign req_stall  = (count_ff > 3'd1);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != 3'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign rsp_out_byte = queue_ff[head_ff].out_byte;
   assign rsp_out_last = queue_ff[head_ff].out_last;

   assign plain_hold = (req_in_byte == upd_pkg::CH_PERCENT) && !req_in_last;
   assign plain_byte = (req_in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : req_in_byte;
   assign c_hex      = upd_pkg::is_hex(req_in_byte);
   assign decoded    = {upd_pkg::hex_val(digit_ff), upd_pkg::hex_val(req_in_byte)};

   always_comb begin
      emit_n   = 2'd0;
      pend_in  = upd_pkg::PEND_NONE;
      digit_in = digit_ff;
      for (int k = 0; k < upd_pkg::MAX_RESULTS; k++) begin
         emit_val[k] = '{out_byte: plain_byte, out_last: req_in_last};
      end
      case (pend_ff)
         upd_pkg::PEND_PERCENT: begin
            if (c_hex && !req_in_last) begin
               pend_in  = upd_pkg::PEND_DIGIT;
               digit_in = req_in_byte;
            end else begin
               emit_val[0] = '{out_byte: upd_pkg::CH_PERCENT, out_last: 1'b0};
               if (plain_hold) begin
                  pend_in = upd_pkg::PEND_PERCENT;
                  emit_n  = 2'd1;
               end else begin
                  emit_n  = 2'd2;
               end
            end
         end
         upd_pkg::PEND_DIGIT: begin
            digit_in = 8'd0;
            if (c_hex) begin
               emit_val[0] = '{out_byte: decoded, out_last: req_in_last};
               emit_n      = 2'd1;
            end else begin
               emit_val[0] = '{out_byte: upd_pkg::CH_PERCENT, out_last: 1'b0};
               emit_val[1] = '{out_byte: digit_ff, out_last: 1'b0};
               if (plain_hold) begin
                  pend_in = upd_pkg::PEND_PERCENT;
                  emit_n  = 2'd2;
               end else begin
                  emit_n  = 2'd3;
               end
            end
         end
         default: begin
            // nothing held, including the unused code
            if (plain_hold) begin
               pend_in = upd_pkg::PEND_PERCENT;
            end else begin
               emit_n  = 2'd1;
            end
         end
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (rsp_accept) begin
         head_in  = head_ff + 2'd1;
         count_in = count_in - 3'd1;
      end
      if (req_accept) begin
         count_in = count_in + {1'b0, emit_n};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= upd_pkg::PEND_NONE;
         digit_ff <= 8'd0;
         head_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (req_accept) begin
            pend_ff  <= pend_in;
            digit_ff <= digit_in;
         end
      end
   end

   // tail writes land behind whatever is queued, counted from the old head
   always_ff @(posedge clock) begin
      logic [2:0] tail;
      for (int k = 0; k < upd_pkg::MAX_RESULTS; k++) begin
         tail = {1'b0, head_ff} + count_ff + 3'(k);
         if (req_accept && (2'(k) < emit_n)) begin
            queue_ff[tail[1:0]] <= emit_val[k];
         end
      end
   end

endmodule

// ===== hdl/upd_checker.sv =====
// port-level checks for the url percent decoder, bound to the top level
module upd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // a last request always yields at least one byte
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_in_last |=> rsp_valid)
      else $error("last request produced no response");

   // stall toward requests only while responses are backed up
   a_stall_needs_queue: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty response queue");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("response payload changed while stalled");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_in_byte  (req_in_byte),
   .req_in_last  (req_in_last),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

// ===== verif/url_percent_decoder_tb.sv =====
// self-checking testbench for the url percent decoder
`timescale 1ns / 1ps

module url_percent_decoder_tb;

   localparam int CYCLE_LIMIT  = 20000;
   localparam int RANDOM_CHARS = 150;

   typedef struct {
      logic [7:0] ch;
      logic       eos;
      bit         hold;   // wait for the decoder to drain before sending
   } enc_char_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   enc_char_type        encoded_chars[$];
   enc_char_type        cur_char;
   upd_pkg::result_type decoded_due[$];

   upd_pkg::pend_type held_state;
   logic [7:0]        held_digit;

   int errors        = 0;
   int chars_sent    = 0;
   int strings_sent  = 0;
   int bytes_checked = 0;
   int cycles        = 0;

   logic quiet;
   assign quiet = (chars_sent >= 60) && (chars_sent < 120);

   url_percent_decoder DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit hex_char(input logic [7:0] c);
      return (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_NINE) ||
             (c >= upd_pkg::CH_UPPER_A && c <= upd_pkg::CH_UPPER_F) ||
             (c >= upd_pkg::CH_LOWER_A && c <= upd_pkg::CH_LOWER_F);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] n;
      if (c <= upd_pkg::CH_NINE) begin
         n = c - upd_pkg::CH_ZERO;
      end else if (c >= upd_pkg::CH_LOWER_A) begin
         n = c - upd_pkg::CH_LOWER_A + 8'd10;
      end else begin
         n = c - upd_pkg::CH_UPPER_A + 8'd10;
      end
      return n[3:0];
   endfunction

   function automatic void expect_byte(input logic [7:0] b, input logic eos);
      upd_pkg::result_type r;
      r.out_byte = b;
      r.out_last = eos;
      decoded_due.push_back(r);
   endfunction

   // decode with nothing held
   function automatic void settle_char(input logic [7:0] c, input logic eos);
      if (c == upd_pkg::CH_PERCENT && !eos) begin
         held_state = upd_pkg::PEND_PERCENT;
      end else if (c == upd_pkg::CH_PLUS) begin
         expect_byte(upd_pkg::CH_SPACE, eos);
      end else begin
         expect_byte(c, eos);
      end
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic eos);
      upd_pkg::pend_type was;
      was = held_state;
      held_state = upd_pkg::PEND_NONE;
      case (was)
         upd_pkg::PEND_PERCENT: begin
            if (hex_char(c) && !eos) begin
               held_digit = c;
               held_state = upd_pkg::PEND_DIGIT;
            end else begin
               expect_byte(upd_pkg::CH_PERCENT, 1'b0);
               settle_char(c, eos);
            end
         end
         upd_pkg::PEND_DIGIT: begin
            if (hex_char(c)) begin
               expect_byte({nibble_of(held_digit), nibble_of(c)}, eos);
            end else begin
               expect_byte(upd_pkg::CH_PERCENT, 1'b0);
               expect_byte(held_digit, 1'b0);
               settle_char(c, eos);
            end
            held_digit = 8'h00;
         end
         default: settle_char(c, eos);
      endcase
   endfunction

   function automatic void queue_char(input logic [7:0] c, input logic eos);
      enc_char_type e;
      e.ch   = c;
      e.eos  = eos;
      e.hold = 1'b0;
      encoded_chars.push_back(e);
   endfunction

   function automatic logic [7:0] random_hex();
      logic [3:0] n;
      n = 4'($urandom_range(15));
      if (n < 10) begin
         return upd_pkg::CH_ZERO + 8'(n);
      end
      return ($urandom_range(1) ? upd_pkg::CH_LOWER_A : upd_pkg::CH_UPPER_A) + 8'(n) - 8'd10;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_char(cur_char.ch, cur_char.eos);
            chars_sent++;
            if (cur_char.eos) strings_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (encoded_chars.size() != 0 &&
                !(encoded_chars[0].hold && decoded_due.size() != 0) &&
                (quiet || $urandom_range(99) >= 10)) begin
               cur_char = encoded_chars.pop_front();
               req_valid   <= 1'b1;
               req_in_byte <= cur_char.ch;
               req_in_last <= cur_char.eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      upd_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_due.size() == 0) begin
               $display("%0t: unexpected decoded byte %h last %b", $time, rsp_out_byte,
                        rsp_out_last);
               errors++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                           rsp_out_byte);
                  errors++;
               end
               if (rsp_out_last !== want.out_last) begin
                  $display("%0t: out_last expected %b actual %b", $time, want.out_last,
                           rsp_out_last);
                  errors++;
               end
               bytes_checked++;
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still due", cycles, decoded_due.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int  len;
      int  roll;
      bit  paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      rsp_stall   = 1'b0;
      held_state  = upd_pkg::PEND_NONE;
      held_digit  = 8'h00;
      paused      = 1'b0;

      // field extremes and a plain plus
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(upd_pkg::CH_PLUS, 1'b0);
      // encoded plus stays a plus
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("2", 1'b0);
      queue_char("B", 1'b0);
      // mixed case escape
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("f", 1'b0);
      queue_char("F", 1'b0);
      // non-hex right after the percent, then a plus after the percent
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("G", 1'b0);
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char(upd_pkg::CH_PLUS, 1'b0);
      // percent after percent becomes the new pending escape
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("4", 1'b0);
      queue_char("1", 1'b0);
      // non-hex as second digit
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("3", 1'b0);
      queue_char("z", 1'b0);
      // escape completed on the last char
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("0", 1'b0);
      queue_char("0", 1'b1);
      // escapes cut by the end of the string
      queue_char(upd_pkg::CH_PERCENT, 1'b1);
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("a", 1'b1);
      queue_char(upd_pkg::CH_PERCENT, 1'b0);
      queue_char("9", 1'b0);
      queue_char(upd_pkg::CH_PLUS, 1'b1);

      // random strings of escapes, lone percents, plus signs, hex digits and noise
      while (encoded_chars.size() < RANDOM_CHARS + 29) begin
         if (!paused && encoded_chars.size() > 110) begin
            queue_char(8'($urandom_range(255)), 1'b0);
            encoded_chars[encoded_chars.size() - 1].hold = 1'b1;
            paused = 1'b1;
         end
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
               queue_char(upd_pkg::CH_PERCENT, 1'b0);
               queue_char(random_hex(), 1'b0);
               queue_char(random_hex(), 1'b0);
            end else if (roll < 50) begin
               queue_char(upd_pkg::CH_PERCENT, 1'b0);
            end else if (roll < 60) begin
               queue_char(upd_pkg::CH_PLUS, 1'b0);
            end else if (roll < 75) begin
               queue_char(random_hex(), 1'b0);
            end else begin
               queue_char(8'($urandom_range(255)), 1'b0);
            end
         end
         encoded_chars[encoded_chars.size() - 1].eos = 1'b1;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (encoded_chars.size() != 0 || req_valid) @(posedge clock);
      while (decoded_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d encoded chars in %0d strings, checked %0d decoded bytes",
               chars_sent, strings_sent, bytes_checked);
      $display("random stalls on both sides, one calm stretch and one drain pause");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/upd_pkg.sv
hdl/url_percent_decoder.sv
hdl/upd_checker.sv
verif/url_percent_decoder_tb.sv
